FILE: design/ttcs_pkg.sv
// ----------------------------------------------------------------------------
// ttcs_pkg
// Shared types and constants for the text terminal with cursor and scroll.
// ----------------------------------------------------------------------------
package ttcs_pkg;

   localparam int DEF_MAX_COLS = 128;
   localparam int DEF_MAX_ROWS = 64;

   localparam int ACTION_W  = 3;
   localparam int CHAR_W    = 8;
   localparam int COL_W     = 7;
   localparam int ROW_W     = 6;
   localparam int COLUMNS_W = 8;
   localparam int ROWS_W    = 7;

   localparam logic [COLUMNS_W-1:0] COLUMNS_RESET = 8'd80;
   localparam logic [ROWS_W-1:0]    ROWS_RESET    = 7'd25;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_COLUMNS = 1'b0;
   localparam logic REG_ROWS    = 1'b1;

   localparam logic [ACTION_W-1:0] ACT_PRINT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUT   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_MOVE  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ  = 3'd4;

   localparam logic [CHAR_W-1:0] NUL_CODE     = 8'd0;
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL,
      ST_CLEAR
   } ttcs_state_type;

   typedef struct packed {
      logic [COLUMNS_W-1:0] columns;
      logic [ROWS_W-1:0]    rows;
   } ttcs_cfg_type;

endpackage

FILE: design/ttcs_ram.sv
// ----------------------------------------------------------------------------
// ttcs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ttcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/ttcs_csr.sv
// ----------------------------------------------------------------------------
// ttcs_csr
// APB-style register file holding the columns and rows settings.
// ----------------------------------------------------------------------------
module ttcs_csr import ttcs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output ttcs_cfg_type          cfg
);

   ttcs_cfg_type cfg_ff;
   logic         reg_sel;
   logic         wr_en;

   assign reg_sel = paddr[2];
   assign wr_en   = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.columns <= COLUMNS_RESET;
         cfg_ff.rows    <= ROWS_RESET;
      end else if (wr_en) begin
         if (reg_sel == REG_COLUMNS) begin
            cfg_ff.columns <= pwdata[COLUMNS_W-1:0];
         end else begin
            cfg_ff.rows <= pwdata[ROWS_W-1:0];
         end
      end
   end

   always_comb begin
      if (reg_sel == REG_COLUMNS) begin
         prdata = {{(CSR_DATA_W-COLUMNS_W){1'b0}}, cfg_ff.columns};
      end else begin
         prdata = {{(CSR_DATA_W-ROWS_W){1'b0}}, cfg_ff.rows};
      end
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

FILE: design/ttcs_ctrl.sv
// ----------------------------------------------------------------------------
// ttcs_ctrl
// Sequencer: executes one item against the screen RAM, runs scroll and
// clear sweeps, and registers the result.
// ----------------------------------------------------------------------------
module ttcs_ctrl import ttcs_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ttcs_cfg_type                         cfg,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ACTION_W-1:0]                  req_action,
   input  logic [CHAR_W-1:0]                    req_char_code,
   input  logic [COL_W-1:0]                     req_col,
   input  logic [ROW_W-1:0]                     req_row,
   output logic                                 rsp_valid,
   output logic [COL_W-1:0]                     rsp_cursor_col,
   output logic [ROW_W-1:0]                     rsp_cursor_row,
   output logic [CHAR_W-1:0]                    rsp_read_char,
   output logic                                 rsp_scrolled,
   output logic                                 mem_we,
   output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] mem_waddr,
   output logic [CHAR_W-1:0]                    mem_wdata,
   output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] mem_raddr,
   input  logic [CHAR_W-1:0]                    mem_rdata
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW1   = $clog2(MAX_COLS + 1);
   localparam int RW1   = $clog2(MAX_ROWS + 1);
   localparam int CEW   = (CW1 > COLUMNS_W) ? CW1 : COLUMNS_W;
   localparam int REW   = (RW1 > ROWS_W) ? RW1 : ROWS_W;

   ttcs_state_type state_ff, state_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [CHAR_W-1:0]   code_ff, code_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [CW-1:0]       cursor_x_ff, cursor_x_in;
   logic [RW-1:0]       cursor_y_ff, cursor_y_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic                emit_ff, emit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic                rsp_scr_ff, rsp_scr_in;

   logic [CEW-1:0]  cols_ext, ncols_w, col_ext, c_w;
   logic [REW-1:0]  rows_ext, nrows_w, row_ext, r_w;
   logic [CW1-1:0]  ncols, cx_ext, cx_w;
   logic [RW1-1:0]  nrows, cy_ext, cy_w;
   logic [CW-1:0]   c, cx;
   logic [RW-1:0]   r, cy;
   logic [CNTW-1:0] total, copy_len, rd_ptr, wr_ptr;
   logic [CW+COL_W-1:0] col_out_w;
   logic [RW+ROW_W-1:0] row_out_w;

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] rr,
                                                input logic [CW-1:0] cc);
      cell_addr = AW'(rr) * AW'(MAX_COLS) + AW'(cc);
   endfunction

   // effective size from the settings
   assign cols_ext = CEW'(cfg.columns);
   assign ncols_w  = (cols_ext == '0) ? CEW'(1) :
                     (cols_ext > CEW'(MAX_COLS)) ? CEW'(MAX_COLS) : cols_ext;
   assign ncols    = ncols_w[CW1-1:0];
   assign rows_ext = REW'(cfg.rows);
   assign nrows_w  = (rows_ext == '0) ? REW'(1) :
                     (rows_ext > REW'(MAX_ROWS)) ? REW'(MAX_ROWS) : rows_ext;
   assign nrows    = nrows_w[RW1-1:0];

   // clamp request coordinates and stored cursor
   assign col_ext = CEW'(col_ff);
   assign c_w     = (col_ext >= CEW'(ncols)) ? CEW'(ncols) - CEW'(1) : col_ext;
   assign c       = c_w[CW-1:0];
   assign row_ext = REW'(row_ff);
   assign r_w     = (row_ext >= REW'(nrows)) ? REW'(nrows) - REW'(1) : row_ext;
   assign r       = r_w[RW-1:0];
   assign cx_ext  = CW1'(cursor_x_ff);
   assign cx_w    = (cx_ext >= ncols) ? ncols - CW1'(1) : cx_ext;
   assign cx      = cx_w[CW-1:0];
   assign cy_ext  = RW1'(cursor_y_ff);
   assign cy_w    = (cy_ext >= nrows) ? nrows - RW1'(1) : cy_ext;
   assign cy      = cy_w[RW-1:0];

   // scroll sweep: read one row below, write one cell behind
   assign total    = CNTW'(nrows) * CNTW'(MAX_COLS);
   assign copy_len = total - CNTW'(MAX_COLS);
   assign rd_ptr   = cnt_ff + CNTW'(MAX_COLS);
   assign wr_ptr   = cnt_ff - CNTW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         emit_ff      <= 1'b0;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         emit_ff      <= emit_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      code_ff     <= code_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_char_ff <= rsp_char_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   always_comb begin
      logic done;
      logic wrap;
      done         = 1'b0;
      wrap         = 1'b0;
      state_in     = state_ff;
      action_in    = action_ff;
      code_in      = code_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      cnt_in       = cnt_ff;
      emit_in      = emit_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = '0;
      rsp_scr_in   = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               action_in = req_action;
               code_in   = req_char_code;
               col_in    = req_col;
               row_in    = req_row;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cursor_x_in = cx;
            cursor_y_in = cy;
            done        = 1'b1;
            case (action_ff)
               ACT_PRINT: begin
                  if (code_ff == NEWLINE_CODE) begin
                     wrap = 1'b1;
                  end else if (code_ff != NUL_CODE) begin
                     mem_we    = 1'b1;
                     mem_waddr = cell_addr(cy, cx);
                     mem_wdata = code_ff;
                     if ((CW1'(cx) + CW1'(1)) >= ncols) begin
                        wrap = 1'b1;
                     end else begin
                        cursor_x_in = cx + CW'(1);
                     end
                  end
                  if (wrap) begin
                     cursor_x_in = '0;
                     if ((RW1'(cy) + RW1'(1)) >= nrows) begin
                        done     = 1'b0;
                        cnt_in   = '0;
                        state_in = ST_SCROLL;
                     end else begin
                        cursor_y_in = cy + RW'(1);
                     end
                  end
               end
               ACT_PUT: begin
                  mem_we    = 1'b1;
                  mem_waddr = cell_addr(r, c);
                  mem_wdata = code_ff;
               end
               ACT_MOVE: begin
                  cursor_x_in = c;
                  cursor_y_in = r;
               end
               ACT_CLEAR: begin
                  done        = 1'b0;
                  cursor_x_in = '0;
                  cursor_y_in = '0;
                  cnt_in      = '0;
                  emit_in     = 1'b1;
                  state_in    = ST_CLEAR;
               end
               ACT_READ: begin
                  done      = 1'b0;
                  mem_raddr = cell_addr(r, c);
                  state_in  = ST_READ;
               end
               default: begin
               end
            endcase
            if (done) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = mem_rdata;
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            if (cnt_ff < copy_len) begin
               mem_raddr = rd_ptr[AW-1:0];
            end
            if (cnt_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = wr_ptr[AW-1:0];
               mem_wdata = (wr_ptr < copy_len) ? mem_rdata : '0;
            end
            if (cnt_ff == total) begin
               rsp_valid_in = 1'b1;
               rsp_scr_in   = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNTW'(1);
            end
         end
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[AW-1:0];
            mem_wdata = '0;
            if (cnt_ff == CNTW'(DEPTH - 1)) begin
               rsp_valid_in = emit_ff;
               emit_in      = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + CNTW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      col_out_w  = {{COL_W{1'b0}}, cursor_x_in};
      row_out_w  = {{ROW_W{1'b0}}, cursor_y_in};
      rsp_col_in = col_out_w[COL_W-1:0];
      rsp_row_in = row_out_w[ROW_W-1:0];
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_read_char  = rsp_char_ff;
   assign rsp_scrolled   = rsp_scr_ff;

endmodule

FILE: design/text_terminal_cursor_scroll_core.sv
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_core
// Character terminal over a MAX_ROWS x MAX_COLS byte screen RAM with cursor,
// wrap, newline, scroll, put, move, clear and read.
//
// Issue a command by raising start with the req_ fields while busy is low;
// the transfer happens at that edge. Exactly one result follows, shown for
// one cycle with rsp_valid high; the receiver cannot stall it.
// Steps from the accepting edge to the result cycle:
//   print, put, move, unused codes: execute, then the result register
//   read: execute, then the registered RAM read, then the result register
//   print that scrolls: execute, then a row copy sweep over rows*MAX_COLS cells
//   clear: execute, then a zero sweep over all MAX_COLS*MAX_ROWS cells
// A new command is taken from the cycle that shows the result, when busy is
// already low; none is taken while busy is high. The single RAM port pair sets
// all sweep lengths. After reset the block clears the screen RAM with busy
// high; settings writes over the csr port are taken at any time.
// ----------------------------------------------------------------------------
module text_terminal_cursor_scroll_core import ttcs_pkg::*; #(
   parameter int MAX_COLS = DEF_MAX_COLS,
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [COL_W-1:0]      req_col,
   input  logic [ROW_W-1:0]      req_row,
   output logic                  rsp_valid,
   output logic [COL_W-1:0]      rsp_cursor_col,
   output logic [ROW_W-1:0]      rsp_cursor_row,
   output logic [CHAR_W-1:0]     rsp_read_char,
   output logic                  rsp_scrolled,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);

   ttcs_cfg_type      cfg;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CHAR_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [CHAR_W-1:0] mem_rdata;

   ttcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ttcs_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (DEPTH)
   ) u_screen_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   ttcs_ctrl #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_read_char  (rsp_read_char),
      .rsp_scrolled   (rsp_scrolled),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text terminal core. Commands go in over the
// start/busy port and every cursor report is compared field by field with a
// screen tracker that mirrors the character store, cursor, wrap, newline and
// scroll. Screen size settings go through the APB port between bursts. They
// range from 1x1 to the full store, and the out-of-range values are included.
// ----------------------------------------------------------------------------
module tb import ttcs_pkg::*; ();

   localparam int SCREEN_COLS   = DEF_MAX_COLS;
   localparam int SCREEN_ROWS   = DEF_MAX_ROWS;
   localparam int SETTLE_CYCLES = 8;
   localparam int NUM_PHASES    = 10;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = ACT_READ + 3'd1;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = '1;

   typedef struct packed {
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic [CHAR_W-1:0] read_char;
      logic              scrolled;
   } cursor_report_type;

   class screen_tracker_type;
      logic [CHAR_W-1:0]    cells [SCREEN_ROWS*SCREEN_COLS];
      logic [COL_W-1:0]     cur_col;
      logic [ROW_W-1:0]     cur_row;
      logic [COLUMNS_W-1:0] columns_reg;
      logic [ROWS_W-1:0]    rows_reg;
      cursor_report_type    awaiting_reports [$];
      int mismatch_count;
      int report_count;
      int command_count;
      int scroll_count;
      int clear_count;
      int read_count;

      function new();
         foreach (cells[i]) cells[i] = '0;
         cur_col        = '0;
         cur_row        = '0;
         columns_reg    = COLUMNS_RESET;
         rows_reg       = ROWS_RESET;
         mismatch_count = 0;
         report_count   = 0;
         command_count  = 0;
         scroll_count   = 0;
         clear_count    = 0;
         read_count     = 0;
      endfunction

      function int cols_in_use();
         if (columns_reg == 0) return 1;
         if (columns_reg > SCREEN_COLS) return SCREEN_COLS;
         return columns_reg;
      endfunction

      function int rows_in_use();
         if (rows_reg == 0) return 1;
         if (rows_reg > SCREEN_ROWS) return SCREEN_ROWS;
         return rows_reg;
      endfunction

      function int outstanding();
         return awaiting_reports.size();
      endfunction

      function void apply_setting(logic reg_index, logic [CSR_DATA_W-1:0] value);
         if (reg_index == REG_COLUMNS) columns_reg = value[COLUMNS_W-1:0];
         else rows_reg = value[ROWS_W-1:0];
      endfunction

      function void note_failure(string what, logic [31:0] want, logic [31:0] got);
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
      endfunction

      // Column 0 of the next row; scroll the rows in use when past the bottom.
      function bit advance_line(int nrows);
         cur_col = '0;
         if (cur_row + 1 >= nrows) begin
            for (int r = 0; r < nrows - 1; r++)
               for (int c = 0; c < SCREEN_COLS; c++)
                  cells[r*SCREEN_COLS + c] = cells[(r+1)*SCREEN_COLS + c];
            for (int c = 0; c < SCREEN_COLS; c++)
               cells[(nrows-1)*SCREEN_COLS + c] = '0;
            return 1'b1;
         end
         cur_row = cur_row + 1'b1;
         return 1'b0;
      endfunction

      function void take_command(logic [ACTION_W-1:0] action, logic [CHAR_W-1:0] code,
                                 logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
         int ncols;
         int nrows;
         int c;
         int r;
         cursor_report_type rep;
         ncols = cols_in_use();
         nrows = rows_in_use();
         c = (col >= ncols) ? ncols - 1 : col;
         r = (row >= nrows) ? nrows - 1 : row;
         if (cur_col >= ncols) cur_col = COL_W'(ncols - 1);
         if (cur_row >= nrows) cur_row = ROW_W'(nrows - 1);
         rep = '0;
         case (action)
            ACT_PRINT: begin
               if (code == NEWLINE_CODE) begin
                  rep.scrolled = advance_line(nrows);
               end else if (code != NUL_CODE) begin
                  cells[cur_row*SCREEN_COLS + cur_col] = code;
                  if (cur_col + 1 >= ncols) rep.scrolled = advance_line(nrows);
                  else cur_col = cur_col + 1'b1;
               end
            end
            ACT_PUT: cells[r*SCREEN_COLS + c] = code;
            ACT_MOVE: begin
               cur_col = COL_W'(c);
               cur_row = ROW_W'(r);
            end
            ACT_CLEAR: begin
               foreach (cells[i]) cells[i] = '0;
               cur_col = '0;
               cur_row = '0;
               clear_count++;
            end
            ACT_READ: begin
               rep.read_char = cells[r*SCREEN_COLS + c];
               read_count++;
            end
            default: ;
         endcase
         rep.cursor_col = cur_col;
         rep.cursor_row = cur_row;
         if (rep.scrolled) scroll_count++;
         command_count++;
         awaiting_reports.push_back(rep);
      endfunction

      function void check_report(cursor_report_type got);
         cursor_report_type want;
         if (awaiting_reports.size() == 0) begin
            note_failure("result with no command outstanding, cursor column", '0,
                         got.cursor_col);
            return;
         end
         want = awaiting_reports.pop_front();
         report_count++;
         if (got.cursor_col !== want.cursor_col)
            note_failure($sformatf("result %0d cursor column", report_count),
                         want.cursor_col, got.cursor_col);
         if (got.cursor_row !== want.cursor_row)
            note_failure($sformatf("result %0d cursor row", report_count),
                         want.cursor_row, got.cursor_row);
         if (got.read_char !== want.read_char)
            note_failure($sformatf("result %0d read char", report_count),
                         want.read_char, got.read_char);
         if (got.scrolled !== want.scrolled)
            note_failure($sformatf("result %0d scrolled", report_count),
                         want.scrolled, got.scrolled);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [ACTION_W-1:0]   req_action;
   logic [CHAR_W-1:0]     req_char_code;
   logic [COL_W-1:0]      req_col;
   logic [ROW_W-1:0]      req_row;
   logic                  rsp_valid;
   logic [COL_W-1:0]      rsp_cursor_col;
   logic [ROW_W-1:0]      rsp_cursor_row;
   logic [CHAR_W-1:0]     rsp_read_char;
   logic                  rsp_scrolled;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   text_terminal_cursor_scroll_core #(
      .MAX_COLS(SCREEN_COLS),
      .MAX_ROWS(SCREEN_ROWS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_read_char  (rsp_read_char),
      .rsp_scrolled   (rsp_scrolled),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   screen_tracker_type tracker = new();
   int cycle_count     = 0;
   int cycle_allowance = SCREEN_COLS*SCREEN_ROWS + 1000;
   int idle_pct        = 0;

   int phase_columns [NUM_PHASES] = '{1, 8, 255, 0, 40, 128, 3, 128, 80, 129};
   int phase_rows    [NUM_PHASES] = '{1, 4, 127, 0, 12, 2, 7, 64, 25, 65};
   int phase_items   [NUM_PHASES] = '{200, 350, 40, 150, 350, 250, 300, 40, 170, 20};
   bit phase_heavy   [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 0, 1, 0, 1};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 4 * cycle_allowance) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid)
         tracker.check_report({rsp_cursor_col, rsp_cursor_row, rsp_read_char, rsp_scrolled});

   task automatic issue_command(input logic [ACTION_W-1:0] action,
                                input logic [CHAR_W-1:0] code,
                                input logic [COL_W-1:0] col,
                                input logic [ROW_W-1:0] row);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         cycle_allowance += 1;
         @(posedge clock);
      end
      req_action    <= action;
      req_char_code <= code;
      req_col       <= col;
      req_row       <= row;
      start         <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (action == ACT_PRINT) cycle_allowance += tracker.rows_in_use()*SCREEN_COLS + 16;
      else if (action == ACT_CLEAR) cycle_allowance += SCREEN_COLS*SCREEN_ROWS + 16;
      else cycle_allowance += 16;
      tracker.take_command(action, code, col, row);
   endtask

   task automatic wait_for_quiet();
      start <= 1'b0;
      do @(negedge clock); while (tracker.outstanding() != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
      cycle_allowance += SETTLE_CYCLES + 2;
   endtask

   // Write one setting, then read it back.
   task automatic program_setting(input logic reg_index, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] mask;
      mask = (reg_index == REG_COLUMNS) ? (32'd1 << COLUMNS_W) - 1 : (32'd1 << ROWS_W) - 1;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.apply_setting(reg_index, value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== (value & mask))
         tracker.note_failure("setting readback", value & mask, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      cycle_allowance += 8;
   endtask

   task automatic random_command(input bit heavy);
      int pick;
      int sel;
      int span_c;
      int span_r;
      logic [ACTION_W-1:0] action;
      logic [CHAR_W-1:0]   code;
      logic [COL_W-1:0]    col;
      logic [ROW_W-1:0]    row;
      span_c = tracker.cols_in_use();
      span_r = tracker.rows_in_use();
      pick   = $urandom_range(0, 999);
      code   = CHAR_W'($urandom_range(0, 255));
      col    = COL_W'($urandom_range(0, 127));
      row    = ROW_W'($urandom_range(0, 63));
      // Keep most coordinates on screen.
      if ($urandom_range(0, 3) != 0) begin
         col = COL_W'($urandom_range(0, span_c - 1));
         row = ROW_W'($urandom_range(0, span_r - 1));
      end
      if (heavy) begin
         if (pick < 150) action = ACT_PRINT;
         else if (pick < 450) action = ACT_PUT;
         else if (pick < 650) begin
            action = ACT_MOVE;
            if (pick < 550) row = ROW_W'(span_r - 1);
         end else action = ACT_READ;
      end else begin
         if (pick < 450) action = ACT_PRINT;
         else if (pick < 630) action = ACT_PUT;
         else if (pick < 770) action = ACT_MOVE;
         else if (pick < 970) action = ACT_READ;
         else if (pick < 980) action = ACT_CLEAR;
         else action = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      end
      if (action == ACT_PRINT) begin
         sel = $urandom_range(0, 99);
         if (sel < 15) code = NEWLINE_CODE;
         else if (sel < 20) code = NUL_CODE;
      end
      issue_command(action, code, col, row);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] value;
      int total_items;
      int issued;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_action    <= ACT_PRINT;
      req_char_code <= '0;
      req_col       <= '0;
      req_row       <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      total_items = 0;
      issued      = 0;
      foreach (phase_items[p]) total_items += phase_items[p];
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Power-up screen size: wrap, scroll, clamping, NUL, unused codes, clear.
      issue_command(ACT_PRINT, 8'h41, '0, '0);
      issue_command(ACT_PRINT, NUL_CODE, '0, '0);
      issue_command(ACT_PRINT, NEWLINE_CODE, '0, '0);
      issue_command(ACT_PRINT, 8'hFF, '0, '0);
      issue_command(ACT_PUT, 8'hAA, '1, '1);
      issue_command(ACT_READ, '0, '1, '1);
      issue_command(ACT_MOVE, '0, '1, '1);
      issue_command(ACT_PRINT, 8'h55, '0, '0);
      issue_command(ACT_READ, '0, 7'd79, 6'd23);
      issue_command(ACT_READ, '0, 7'd79, 6'd24);
      issue_command(ACT_READ, '0, '0, '0);
      issue_command(ACT_MOVE, '0, 7'd5, 6'd24);
      issue_command(ACT_PRINT, NEWLINE_CODE, '0, '0);
      issue_command(ACT_PUT, 8'h7F, '0, '0);
      issue_command(ACT_READ, '0, '0, '0);
      issue_command(ACT_UNUSED_LO, 8'hFF, '1, '1);
      issue_command(ACT_UNUSED_LO + 3'd1, '0, '0, '0);
      issue_command(ACT_UNUSED_HI, 8'h80, 7'h2A, 6'h15);
      issue_command(ACT_CLEAR, 8'hFF, '1, '1);
      issue_command(ACT_READ, '0, 7'd79, 6'd23);
      issue_command(ACT_MOVE, '0, 7'h55, 6'h2A);
      issue_command(ACT_PRINT, 8'h80, '0, '0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_for_quiet();
         value = $urandom();
         value[COLUMNS_W-1:0] = COLUMNS_W'(phase_columns[p]);
         program_setting(REG_COLUMNS, value);
         value = $urandom();
         value[ROWS_W-1:0] = ROWS_W'(phase_rows[p]);
         program_setting(REG_ROWS, value);
         if (phase_heavy[p]) begin
            issue_command(ACT_MOVE, '0, '0, '1);
            issue_command(ACT_PRINT, NEWLINE_CODE, '0, '0);
         end
         for (int n = 0; n < phase_items[p]; n++) begin
            if (issued < total_items / 3) idle_pct = 34;
            else if (issued < 2 * total_items / 3) idle_pct = 46;
            else idle_pct = 0;
            if ($urandom_range(0, 49) == 0) wait_for_quiet();
            random_command(phase_heavy[p]);
            issued++;
         end
      end

      wait_for_quiet();
      $display("Ran %0d commands over %0d screen sizes: %0d scrolls, %0d clears, %0d reads",
               tracker.command_count, NUM_PHASES + 1, tracker.scroll_count,
               tracker.clear_count, tracker.read_count);
      $display("Checked %0d cursor reports, %0d mismatches, %0d left outstanding",
               tracker.report_count, tracker.mismatch_count, tracker.outstanding());
      if (tracker.mismatch_count == 0 && tracker.outstanding() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
